FILE: sv/whem_pkg.sv
// Shared types and constants of the window histogram entropy monitor.
// Used by every module of the block except whem_ram; depends on nothing.
package whem_pkg;

    localparam int unsigned DEF_MAX_WINDOW  = 256;
    localparam int unsigned DEF_MAX_BUCKETS = 16;
    localparam int unsigned DEF_SAMPLE_BITS = 16;

    // fraction bits of the fixed-point log2
    localparam int unsigned LOG_FRAC = 30;
    // quotient bits of the entropy divider
    localparam int unsigned DIV_QW   = 18;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned WIN_W      = 9;
    localparam int unsigned MINS_W     = 9;
    localparam int unsigned BKT_W      = 5;
    localparam int unsigned THR_W      = 16;
    localparam int unsigned ENT_W      = 16;
    localparam int unsigned CNT_W      = 32;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EVAL_FILL      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 3'd4;

    localparam logic [WIN_W-1:0]  RST_WINDOW_LEN     = 9'd64;
    localparam logic [MINS_W-1:0] RST_EVAL_FILL      = 9'd16;
    localparam logic [BKT_W-1:0]  RST_BUCKET_COUNT   = 5'd8;
    localparam logic [THR_W-1:0]  RST_HIGH_THRESHOLD = 16'd52429;
    localparam logic [THR_W-1:0]  RST_LOW_THRESHOLD  = 16'd13107;

    typedef enum logic [1:0] {
        LOG_SRC_HIST = 2'd0,
        LOG_SRC_N    = 2'd1,
        LOG_SRC_K    = 2'd2
    } t_log_src;

    typedef struct packed {
        logic     accept;
        logic     clr_hist;
        logic     rd_init;
        logic     mm_issue;
        logic     set_range;
        logic     set_thr;
        logic     bin_issue;
        logic     j_inc;
        logic     log_start;
        t_log_src log_src;
        logic     mac;
        logic     acc;
        logic     hnum_ld;
        logic     den_ld;
        logic     div_init;
        logic     div_step;
        logic     fin;
        logic     fin_eval;
    } t_cmd;

    typedef struct packed {
        logic eval_ok;
        logic k_one;
        logic rd_last;
        logic pipe_busy;
        logic j_done;
        logic hist_zero;
        logic log_done;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

FILE: sv/whem_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module whem_ram #(
    parameter int unsigned W = 16,
    parameter int unsigned D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/whem_log2.sv
// Iterative fixed-point log2: integer part by priority search, fraction by
// repeated squaring, one fraction bit per cycle. Uses whem_pkg.
module whem_log2 #(
    parameter int unsigned VW = 9,
    parameter int unsigned LW = 34
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [VW-1:0] i_v,
    output logic          o_done,
    output logic [LW-1:0] o_res
);
    import whem_pkg::*;

    localparam int unsigned MW  = LOG_FRAC + 1;
    localparam int unsigned IPW = LW - LOG_FRAC;
    localparam int unsigned SW  = $clog2(LOG_FRAC + 1);
    localparam int unsigned BCW = $clog2(LOG_FRAC);

    logic [IPW-1:0]      ip;
    logic [SW-1:0]       sh;
    logic [MW-1:0]       m0;
    logic [2*MW-1:0]     sq;
    logic [MW:0]         sqs;
    logic [MW-1:0]       r_m;
    logic [IPW-1:0]      r_ip;
    logic [LOG_FRAC-1:0] r_frac;
    logic [BCW-1:0]      r_bit;
    logic                r_busy;
    logic                r_done;

    always_comb begin
        ip = '0;
        for (int b = 1; b < VW; b++) begin
            if (i_v[b]) ip = IPW'(b);
        end
        sh  = SW'(LOG_FRAC) - SW'(ip);
        m0  = MW'(i_v) << sh;
        sq  = r_m * r_m;
        sqs = sq[MW+LOG_FRAC:LOG_FRAC];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_m    <= m0;
            r_ip   <= ip;
            r_frac <= '0;
            r_bit  <= BCW'(LOG_FRAC - 1);
        end else if (r_busy) begin
            if (sqs[MW]) begin
                r_m           <= sqs[MW:1];
                r_frac[r_bit] <= 1'b1;
            end else begin
                r_m <= sqs[MW-1:0];
            end
            r_bit <= r_bit - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_res  = {r_ip, r_frac};

endmodule

FILE: sv/whem_dp.sv
// Datapath: config registers, sample window, min/max and binning passes,
// histogram, entropy accumulation and divider, output register.
// Uses whem_pkg, whem_ram and whem_log2.
module whem_dp #(
    parameter int unsigned MAX_WINDOW  = whem_pkg::DEF_MAX_WINDOW,
    parameter int unsigned MAX_BUCKETS = whem_pkg::DEF_MAX_BUCKETS,
    parameter int unsigned SAMPLE_BITS = whem_pkg::DEF_SAMPLE_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  whem_pkg::t_cmd                     i_cmd,
    output whem_pkg::t_sts                     o_sts,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [whem_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [whem_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [whem_pkg::ENT_W-1:0]         o_entropy_q16,
    output logic                               o_evaluated,
    output logic                               o_high_event,
    output logic                               o_low_event,
    output logic [whem_pkg::CNT_W-1:0]         o_high_count,
    output logic [whem_pkg::CNT_W-1:0]         o_low_count,
    output logic [whem_pkg::CNT_W-1:0]         o_sample_count
);
    import whem_pkg::*;

    localparam int unsigned AW  = $clog2(MAX_WINDOW);
    localparam int unsigned NW  = $clog2(MAX_WINDOW + 1);
    localparam int unsigned KW  = $clog2(MAX_BUCKETS + 1);
    localparam int unsigned BW  = $clog2(MAX_BUCKETS);
    localparam int unsigned DW  = SAMPLE_BITS + 1;
    localparam int unsigned TW  = DW + KW;
    localparam int unsigned VW  = (NW > KW) ? NW : KW;
    localparam int unsigned LW  = LOG_FRAC + $clog2(VW);
    localparam int unsigned PW  = NW + LW;
    localparam int unsigned DVW = PW + DIV_QW;
    localparam int unsigned QBW = $clog2(DIV_QW);

    // config
    logic [WIN_W-1:0]  r_cfg_win;
    logic [MINS_W-1:0] r_cfg_mins;
    logic [BKT_W-1:0]  r_cfg_k;
    logic [THR_W-1:0]  r_cfg_hi;
    logic [THR_W-1:0]  r_cfg_lo;

    logic [NW-1:0] win_n;
    logic [KW-1:0] k_n;

    // window
    logic [AW-1:0]          r_wp;
    logic [NW-1:0]          r_fill;
    logic [AW-1:0]          wp_eff;
    logic [AW-1:0]          n_wp;
    logic [NW-1:0]          n_fill;
    logic [AW-1:0]          r_idx;
    logic [SAMPLE_BITS-1:0] w_rdata;

    // passes
    logic                          r_v1_mm, r_v1_bin, r_v2, r_v3, r_first;
    logic signed [SAMPLE_BITS-1:0] r_min, r_max;
    logic [DW-1:0]                 r_range;
    logic [DW-1:0]                 diff_x;
    logic [TW-1:0]                 r_thr [MAX_BUCKETS-1:1];
    logic [TW-1:0]                 r_num;
    logic [BW-1:0]                 bkt, r_bkt, hidx;
    logic [NW-1:0]                 r_hist [MAX_BUCKETS];
    logic [NW-1:0]                 hval;
    logic [KW-1:0]                 r_j;

    // entropy
    logic [VW-1:0]     log_v;
    logic              log_done;
    logic [LW-1:0]     log_res;
    logic [PW-1:0]     r_prod, r_sum, r_hnum, r_den, hdiff;
    logic [DVW-1:0]    r_rem, r_dsh;
    logic [DIV_QW-1:0] r_q;
    logic [QBW-1:0]    r_qbit;

    // result
    logic             r_ov;
    logic [ENT_W-1:0] r_o_ent;
    logic             r_o_eval, r_o_hev, r_o_lev;
    logic [CNT_W-1:0] r_o_smp;
    logic             r_was_hi, r_was_lo;
    logic [CNT_W-1:0] r_hi_cnt, r_lo_cnt, r_smp_cnt;
    logic [ENT_W-1:0] ent;
    logic             hi_st, lo_st;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_win  <= RST_WINDOW_LEN;
            r_cfg_mins <= RST_EVAL_FILL;
            r_cfg_k    <= RST_BUCKET_COUNT;
            r_cfg_hi   <= RST_HIGH_THRESHOLD;
            r_cfg_lo   <= RST_LOW_THRESHOLD;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WINDOW_LEN:     r_cfg_win  <= i_cfg_data[WIN_W-1:0];
                REG_EVAL_FILL:      r_cfg_mins <= i_cfg_data[MINS_W-1:0];
                REG_BUCKET_COUNT:   r_cfg_k    <= i_cfg_data[BKT_W-1:0];
                REG_HIGH_THRESHOLD: r_cfg_hi   <= i_cfg_data[THR_W-1:0];
                REG_LOW_THRESHOLD:  r_cfg_lo   <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp window length and bucket count into their legal ranges, and work out the next write pointer and fill level
    always_comb begin
        if (r_cfg_win == '0) begin
            win_n = NW'(1);
        end else if (32'(r_cfg_win) > 32'(MAX_WINDOW)) begin
            win_n = NW'(MAX_WINDOW);
        end else begin
            win_n = NW'(r_cfg_win);
        end
        if (r_cfg_k == '0) begin
            k_n = KW'(1);
        end else if (32'(r_cfg_k) > 32'(MAX_BUCKETS)) begin
            k_n = KW'(MAX_BUCKETS);
        end else begin
            k_n = KW'(r_cfg_k);
        end
        wp_eff = (NW'(r_wp) >= win_n) ? '0 : r_wp;
        n_wp   = (NW'(wp_eff) + NW'(1) >= win_n) ? '0 : wp_eff + 1'b1;
        n_fill = (r_fill < win_n) ? r_fill + 1'b1 : win_n;
    end

    whem_ram #(
        .W (SAMPLE_BITS),
        .D (MAX_WINDOW)
    ) u_win (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept),
        .i_waddr (wp_eff),
        .i_wdata (i_sample),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_fill    <= '0;
            r_smp_cnt <= '0;
        end else if (i_cmd.accept) begin
            r_wp      <= n_wp;
            r_fill    <= n_fill;
            r_smp_cnt <= (&r_smp_cnt) ? r_smp_cnt : r_smp_cnt + 1'b1;
        end
    end

    // read pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1_mm  <= 1'b0;
            r_v1_bin <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
        end else begin
            r_v1_mm  <= i_cmd.mm_issue;
            r_v1_bin <= i_cmd.bin_issue;
            r_v2     <= r_v1_bin;
            r_v3     <= r_v2;
        end
    end

    assign diff_x = {w_rdata[SAMPLE_BITS-1], w_rdata} - {r_min[SAMPLE_BITS-1], r_min};

    always_comb begin
        bkt = '0;
        for (int j = 1; j < MAX_BUCKETS; j++) begin
            if ((KW'(j) < k_n) && (r_thr[j] <= r_num)) bkt = BW'(j);
        end
        if (r_range == '0) bkt = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_init) begin
            r_idx   <= '0;
            r_first <= 1'b1;
        end else if (i_cmd.mm_issue || i_cmd.bin_issue) begin
            r_idx <= r_idx + 1'b1;
        end
        if (r_v1_mm) begin
            r_first <= 1'b0;
            if (r_first || $signed(w_rdata) < r_min) r_min <= $signed(w_rdata);
            if (r_first || $signed(w_rdata) > r_max) r_max <= $signed(w_rdata);
        end
        if (i_cmd.set_range) begin
            r_range <= {r_max[SAMPLE_BITS-1], r_max} - {r_min[SAMPLE_BITS-1], r_min};
        end
        if (i_cmd.set_thr) begin
            for (int j = 1; j < MAX_BUCKETS; j++) begin
                r_thr[j] <= TW'(r_range) * TW'(j);
            end
        end
        if (r_v1_bin) r_num <= TW'(diff_x) * TW'(k_n);
        if (r_v2) r_bkt <= bkt;
    end

    assign hidx = r_v3 ? r_bkt : BW'(r_j);
    assign hval = r_hist[hidx];

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_hist) begin
            for (int j = 0; j < MAX_BUCKETS; j++) r_hist[j] <= '0;
            r_j   <= '0;
            r_sum <= '0;
        end else begin
            if (r_v3) r_hist[hidx] <= hval + 1'b1;
            if (i_cmd.j_inc) r_j <= r_j + 1'b1;
            if (i_cmd.acc) r_sum <= r_sum + r_prod;
        end
    end

    always_comb begin
        case (i_cmd.log_src)
            LOG_SRC_HIST: log_v = VW'(hval);
            LOG_SRC_N:    log_v = VW'(r_fill);
            LOG_SRC_K:    log_v = VW'(k_n);
            default:      log_v = VW'(r_fill);
        endcase
    end

    whem_log2 #(
        .VW (VW),
        .LW (LW)
    ) u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.log_start),
        .i_v     (log_v),
        .o_done  (log_done),
        .o_res   (log_res)
    );

    assign hdiff = (r_hnum > r_sum) ? r_hnum - r_sum : '0;

    // restoring divide: (H*65536 + den/2) / den, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.mac) r_prod <= PW'(hval) * PW'(log_res);
        if (i_cmd.hnum_ld) r_hnum <= PW'(r_fill) * PW'(log_res);
        if (i_cmd.den_ld) r_den <= PW'(r_fill) * PW'(log_res);
        if (i_cmd.div_init) begin
            r_rem  <= (DVW'(hdiff) << ENT_W) + DVW'(r_den >> 1);
            r_dsh  <= DVW'(r_den) << (DIV_QW - 1);
            r_q    <= '0;
            r_qbit <= QBW'(DIV_QW - 1);
        end else if (i_cmd.div_step) begin
            if (r_dsh <= r_rem) begin
                r_rem       <= r_rem - r_dsh;
                r_q[r_qbit] <= 1'b1;
            end
            r_dsh  <= r_dsh >> 1;
            r_qbit <= r_qbit - 1'b1;
        end
    end

    always_comb begin
        if (!i_cmd.fin_eval || k_n == KW'(1)) begin
            ent = '0;
        end else if (|r_q[DIV_QW-1:ENT_W]) begin
            ent = '1;
        end else begin
            ent = r_q[ENT_W-1:0];
        end
        hi_st = ent > r_cfg_hi;
        lo_st = ent < r_cfg_lo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_was_hi <= 1'b0;
            r_was_lo <= 1'b0;
            r_hi_cnt <= '0;
            r_lo_cnt <= '0;
        end else begin
            if (i_cmd.fin) begin
                r_ov <= 1'b1;
                if (i_cmd.fin_eval) begin
                    r_was_hi <= hi_st;
                    r_was_lo <= lo_st;
                    if (hi_st && !r_was_hi && !(&r_hi_cnt)) r_hi_cnt <= r_hi_cnt + 1'b1;
                    if (lo_st && !r_was_lo && !(&r_lo_cnt)) r_lo_cnt <= r_lo_cnt + 1'b1;
                end
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // sample count is held with the result; the live count moves on the next accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_o_ent  <= ent;
            r_o_eval <= i_cmd.fin_eval;
            r_o_hev  <= i_cmd.fin_eval && hi_st && !r_was_hi;
            r_o_lev  <= i_cmd.fin_eval && lo_st && !r_was_lo;
            r_o_smp  <= r_smp_cnt;
        end
    end

    always_comb begin
        o_sts.eval_ok   = 32'(r_fill) >= 32'(r_cfg_mins);
        o_sts.k_one     = (k_n == KW'(1));
        o_sts.rd_last   = (NW'(r_idx) == r_fill - 1'b1);
        o_sts.pipe_busy = r_v1_bin | r_v2 | r_v3;
        o_sts.j_done    = (r_j == k_n);
        o_sts.hist_zero = (hval == '0);
        o_sts.log_done  = log_done;
        o_sts.div_last  = (r_qbit == '0);
        o_sts.out_free  = !r_ov || i_out_ready;
    end

    assign o_out_valid    = r_ov;
    assign o_entropy_q16  = r_o_ent;
    assign o_evaluated    = r_o_eval;
    assign o_high_event   = r_o_hev;
    assign o_low_event    = r_o_lev;
    assign o_high_count   = r_hi_cnt;
    assign o_low_count    = r_lo_cnt;
    assign o_sample_count = r_o_smp;

endmodule

FILE: sv/whem_ctrl.sv
// Sequencer for one request: window write, min/max pass, binning pass,
// entropy accumulation, divide and result hand-off. Uses whem_pkg.
module whem_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  whem_pkg::t_sts i_sts,
    output whem_pkg::t_cmd o_cmd
);
    import whem_pkg::*;

    typedef enum logic [18:0] {
        S_IDLE     = 19'h00001,
        S_CHECK    = 19'h00002,
        S_MM_RD    = 19'h00004,
        S_MM_END   = 19'h00008,
        S_RANGE    = 19'h00010,
        S_THR      = 19'h00020,
        S_BIN_RD   = 19'h00040,
        S_BIN_END  = 19'h00080,
        S_ENT_SEL  = 19'h00100,
        S_ENT_LOG  = 19'h00200,
        S_ENT_MAC  = 19'h00400,
        S_ENT_ACC  = 19'h00800,
        S_N_LOG    = 19'h01000,
        S_N_MUL    = 19'h02000,
        S_K_LOG    = 19'h04000,
        S_K_MUL    = 19'h08000,
        S_DIV_INIT = 19'h10000,
        S_DIV      = 19'h20000,
        S_FIN      = 19'h40000
    } t_state;

    t_state r_state, n_state;
    logic   r_eval, n_eval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_eval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_eval  <= n_eval;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_eval        = r_eval;
        o_cmd         = '0;
        o_cmd.log_src = LOG_SRC_HIST;
        o_cmd.fin_eval = r_eval;
        o_in_ready    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            S_CHECK: begin
                n_eval = i_sts.eval_ok;
                if (!i_sts.eval_ok || i_sts.k_one) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.clr_hist = 1'b1;
                    o_cmd.rd_init  = 1'b1;
                    n_state        = S_MM_RD;
                end
            end
            S_MM_RD: begin
                o_cmd.mm_issue = 1'b1;
                if (i_sts.rd_last) n_state = S_MM_END;
            end
            S_MM_END: n_state = S_RANGE;
            S_RANGE: begin
                o_cmd.set_range = 1'b1;
                n_state         = S_THR;
            end
            S_THR: begin
                o_cmd.set_thr = 1'b1;
                o_cmd.rd_init = 1'b1;
                n_state       = S_BIN_RD;
            end
            S_BIN_RD: begin
                o_cmd.bin_issue = 1'b1;
                if (i_sts.rd_last) n_state = S_BIN_END;
            end
            S_BIN_END: begin
                if (!i_sts.pipe_busy) n_state = S_ENT_SEL;
            end
            S_ENT_SEL: begin
                if (i_sts.j_done) begin
                    o_cmd.log_start = 1'b1;
                    o_cmd.log_src   = LOG_SRC_N;
                    n_state         = S_N_LOG;
                end else if (i_sts.hist_zero) begin
                    o_cmd.j_inc = 1'b1;
                end else begin
                    o_cmd.log_start = 1'b1;
                    n_state         = S_ENT_LOG;
                end
            end
            S_ENT_LOG: begin
                if (i_sts.log_done) n_state = S_ENT_MAC;
            end
            S_ENT_MAC: begin
                o_cmd.mac = 1'b1;
                n_state   = S_ENT_ACC;
            end
            S_ENT_ACC: begin
                o_cmd.acc   = 1'b1;
                o_cmd.j_inc = 1'b1;
                n_state     = S_ENT_SEL;
            end
            S_N_LOG: begin
                if (i_sts.log_done) n_state = S_N_MUL;
            end
            S_N_MUL: begin
                o_cmd.hnum_ld   = 1'b1;
                o_cmd.log_start = 1'b1;
                o_cmd.log_src   = LOG_SRC_K;
                n_state         = S_K_LOG;
            end
            S_K_LOG: begin
                if (i_sts.log_done) n_state = S_K_MUL;
            end
            S_K_MUL: begin
                o_cmd.den_ld = 1'b1;
                n_state      = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |-> i_sts.out_free)
        else $error("result loaded while output register busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second request taken before first finished");

    a_log_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.log_done |-> (r_state == S_ENT_LOG || r_state == S_N_LOG ||
                            r_state == S_K_LOG))
        else $error("log2 finished outside a wait state");

    a_bin_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ENT_SEL) |-> !i_sts.pipe_busy)
        else $error("entropy pass started with binning in flight");

endmodule

FILE: sv/window_histogram_entropy_monitor_core.sv
// Sliding-window histogram entropy monitor, top level.
// Uses whem_pkg, whem_ctrl and whem_dp.
//
// Input channel (i_in_valid/o_in_ready, i_sample): one signed sample per
// request. Config channel (i_cfg_valid/o_cfg_ready, i_cfg_index,
// i_cfg_data) is always ready; write it only while the block is idle.
// Output channel (o_out_valid/i_out_ready): one result per request with
// entropy Q0.16, the evaluated and event flags and the three counters.
// One request is worked at a time. A sample whose fill level is below the
// evaluation threshold, or any sample with bucket_count 0 or 1, goes from the
// check straight to the result hand-off. An evaluated sample reads the window
// twice (min/max pass, then binning pass) through the window RAM read port,
// then calls the serial log2 unit (one fraction bit per cycle) once for each
// non-empty bucket and once each for the fill level and the bucket count. The
// result becomes valid in the same cycle in which the next sample can be taken.
// Reset (synchronous, active low) restores config defaults and clears
// pointers, flags and counters; the window RAM is not cleared.
// If the receiver stalls, the finished result waits in the output
// register; the next sample is taken and worked up to its hand-off.
module window_histogram_entropy_monitor_core #(
    parameter int unsigned MAX_WINDOW  = whem_pkg::DEF_MAX_WINDOW,
    parameter int unsigned MAX_BUCKETS = whem_pkg::DEF_MAX_BUCKETS,
    parameter int unsigned SAMPLE_BITS = whem_pkg::DEF_SAMPLE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]   i_sample,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [whem_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [whem_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [whem_pkg::ENT_W-1:0]      o_entropy_q16,
    output logic                            o_evaluated,
    output logic                            o_high_event,
    output logic                            o_low_event,
    output logic [whem_pkg::CNT_W-1:0]      o_high_count,
    output logic [whem_pkg::CNT_W-1:0]      o_low_count,
    output logic [whem_pkg::CNT_W-1:0]      o_sample_count
);
    import whem_pkg::*;

    t_cmd cmd;
    t_sts sts;

    whem_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    whem_dp #(
        .MAX_WINDOW  (MAX_WINDOW),
        .MAX_BUCKETS (MAX_BUCKETS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_sample       (i_sample),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_entropy_q16  (o_entropy_q16),
        .o_evaluated    (o_evaluated),
        .o_high_event   (o_high_event),
        .o_low_event    (o_low_event),
        .o_high_count   (o_high_count),
        .o_low_count    (o_low_count),
        .o_sample_count (o_sample_count)
    );

endmodule

FILE: sim/tb_top.sv
// Testbench for window_histogram_entropy_monitor_core: random and directed samples
// are checked against a built-in predictor of window, histogram, entropy and counters.
// Depends on whem_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_top;
    import whem_pkg::*;

    localparam int unsigned WIN_MAX   = 256;
    localparam int unsigned BKT_MAX   = 16;
    localparam longint      CYC_LIMIT = 6000000;

    typedef struct {
        logic [ENT_W-1:0] entropy;
        logic             evaluated;
        logic             high_ev;
        logic             low_ev;
        logic [CNT_W-1:0] high_cnt;
        logic [CNT_W-1:0] low_cnt;
        logic [CNT_W-1:0] sample_cnt;
    } t_result;

    typedef struct {
        int unsigned win;
        int unsigned mins;
        int unsigned bkt;
        int unsigned hi;
        int unsigned lo;
        int          items;
    } t_phase;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic signed [15:0]    i_sample;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [ENT_W-1:0]      o_entropy_q16;
    logic                  o_evaluated;
    logic                  o_high_event;
    logic                  o_low_event;
    logic [CNT_W-1:0]      o_high_count;
    logic [CNT_W-1:0]      o_low_count;
    logic [CNT_W-1:0]      o_sample_count;

    window_histogram_entropy_monitor_core i_dut (.*);

    // predictor state
    logic signed [15:0] win_mem [WIN_MAX];
    int unsigned cfg_win, cfg_mins, cfg_bkt, cfg_hi, cfg_lo;
    int unsigned wr_pos, fill, written_hi;
    bit          was_hi, was_lo;
    logic [CNT_W-1:0] hi_tot, lo_tot, smp_tot;

    logic signed [15:0] sample_q [$];   // waiting to be offered
    logic signed [15:0] accepted_q [$]; // accepted, result pending
    int  errors, results, evals, hi_events, lo_events;
    int  send_pct, recv_pct;
    int  stall_left;
    bit  pressure_done;
    longint cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint unsigned log2_q30(longint unsigned v);
        longint unsigned ip, m, res;
        int i;
        ip = 0;
        if (v < 1) return 0;
        while ((v >> (ip + 1)) != 0) ip++;
        if (ip <= 30) m = v << (30 - ip);
        else m = v >> (ip - 30);
        res = ip << 30;
        for (i = 29; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                m >>= 1;
                res |= 64'd1 << i;
            end
        end
        return res;
    endfunction

    function automatic int unsigned window_entropy(int unsigned n, int unsigned k);
        int unsigned hist [BKT_MAX];
        int vmin, vmax, i;
        longint unsigned span, b, s, hnum, den, q;
        vmin = win_mem[0];
        vmax = win_mem[0];
        for (i = 1; i < n; i++) begin
            if (win_mem[i] < vmin) vmin = win_mem[i];
            if (win_mem[i] > vmax) vmax = win_mem[i];
        end
        foreach (hist[j]) hist[j] = 0;
        span = vmax - vmin;
        if (span != 0) begin
            for (i = 0; i < n; i++) begin
                b = (longint'(win_mem[i] - vmin) * k) / span;
                if (b >= k) b = k - 1;
                hist[b]++;
            end
        end else begin
            hist[0] = n;
        end
        if (k <= 1) return 0;
        s = 0;
        for (i = 0; i < k; i++)
            if (hist[i] > 0) s += longint'(hist[i]) * log2_q30(hist[i]);
        hnum = longint'(n) * log2_q30(n);
        hnum = (hnum > s) ? hnum - s : 0;
        den = longint'(n) * log2_q30(k);
        q = (hnum * 65536 + den / 2) / den;
        return (q > 65535) ? 65535 : int'(q);
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1;
    endfunction

    // Advance the predictor by one sample. The entropy may differ from the block
    // by one LSB; within that, the block's value drives the threshold decisions.
    function automatic t_result predict_step(logic signed [15:0] x, logic [ENT_W-1:0] seen);
        t_result r;
        int unsigned w, k, ent;
        bit h, l;
        w = (cfg_win == 0) ? 1 : (cfg_win > WIN_MAX ? WIN_MAX : cfg_win);
        k = (cfg_bkt == 0) ? 1 : (cfg_bkt > BKT_MAX ? BKT_MAX : cfg_bkt);
        r = '{default: '0};
        if (wr_pos >= w) wr_pos = 0;
        win_mem[wr_pos] = x;
        if (wr_pos + 1 > written_hi) written_hi = wr_pos + 1;
        wr_pos = (wr_pos + 1 >= w) ? 0 : wr_pos + 1;
        fill = (fill < w) ? fill + 1 : w;
        if (fill >= cfg_mins) begin
            r.evaluated = 1'b1;
            ent = window_entropy(fill, k);
            if (k > 1 && (seen == ent || seen + 1 == ent || seen == ent + 1)) ent = seen;
            r.entropy = ent[ENT_W-1:0];
            h = ent > cfg_hi;
            l = ent < cfg_lo;
            if (h && !was_hi) begin r.high_ev = 1'b1; hi_tot = sat_inc(hi_tot); end
            if (l && !was_lo) begin r.low_ev = 1'b1; lo_tot = sat_inc(lo_tot); end
            was_hi = h;
            was_lo = l;
        end
        smp_tot = sat_inc(smp_tot);
        r.high_cnt = hi_tot;
        r.low_cnt = lo_tot;
        r.sample_cnt = smp_tot;
        return r;
    endfunction

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_WINDOW_LEN:     cfg_win = val & 9'h1FF;
            REG_EVAL_FILL:      cfg_mins = val & 9'h1FF;
            REG_BUCKET_COUNT:   cfg_bkt = val & 5'h1F;
            REG_HIGH_THRESHOLD: cfg_hi = val & 16'hFFFF;
            REG_LOW_THRESHOLD:  cfg_lo = val & 16'hFFFF;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (sample_q.size() != 0 || i_in_valid || accepted_q.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_sample(int base);
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'(base + $urandom_range(0, 7));
            2: return 16'(base + 1000 * $urandom_range(0, 4));
            default: return 16'(base);
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) accepted_q.push_back(i_sample);
            if (!i_in_valid || o_in_ready) begin
                if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_pct) begin
                    i_in_valid <= 1'b1;
                    i_sample <= sample_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver
    always @(posedge i_clk) begin
        t_result exp_r;
        logic signed [15:0] x;
        int nxt_stall;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (accepted_q.size() == 0) begin
                    errors++;
                    $display("%0t: result with no request pending, got entropy %0d",
                             $time, o_entropy_q16);
                end else begin
                    x = accepted_q.pop_front();
                    exp_r = predict_step(x, o_entropy_q16);
                    check_field("entropy", exp_r.entropy, o_entropy_q16);
                    check_field("evaluated", exp_r.evaluated, o_evaluated);
                    check_field("high_event", exp_r.high_ev, o_high_event);
                    check_field("low_event", exp_r.low_ev, o_low_event);
                    check_field("high_count", exp_r.high_cnt, o_high_count);
                    check_field("low_count", exp_r.low_cnt, o_low_count);
                    check_field("sample_count", exp_r.sample_cnt, o_sample_count);
                    results++;
                    evals += exp_r.evaluated;
                    hi_events += exp_r.high_ev;
                    lo_events += exp_r.low_ev;
                end
            end
            nxt_stall = (stall_left > 0) ? stall_left - 1 : 0;
            // long hold-off so the block fills and back-pressures its input
            if (!pressure_done && results == 400) begin
                pressure_done <= 1'b1;
                nxt_stall = 3000;
            end
            stall_left <= nxt_stall;
            i_out_ready <= (nxt_stall == 0) && ($urandom_range(0, 99) >= recv_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYC_LIMIT) begin
            $display("%0t: timeout, %0d requests still pending", $time, accepted_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_phase phases [$];
        t_phase ph;
        logic signed [15:0] directed [$];
        int p, i, base;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_sample = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_out_ready = 1'b0;
        errors = 0; results = 0; evals = 0; hi_events = 0; lo_events = 0;
        stall_left = 0; pressure_done = 1'b0; cycles = 0;
        send_pct = 16; recv_pct = 70;
        cfg_win = RST_WINDOW_LEN; cfg_mins = RST_EVAL_FILL; cfg_bkt = RST_BUCKET_COUNT;
        cfg_hi = RST_HIGH_THRESHOLD; cfg_lo = RST_LOW_THRESHOLD;
        wr_pos = 0; fill = 0; written_hi = 0; was_hi = 0; was_lo = 0;
        hi_tot = '0; lo_tot = '0; smp_tot = '0;

        directed = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1, 16'sh5555,
                     16'shAAAA, 16'sd0, 16'sd0, 16'sd0};
        // defaults (directed), max window, crossed thresholds, window of one,
        // zero registers, oversized registers, then random settings
        phases.push_back('{64, 16, 8, 52429, 13107, 20});
        phases.push_back('{256, 256, 16, 65535, 0, 280});
        phases.push_back('{8, 0, 31, 0, 65535, 10});
        phases.push_back('{1, 1, 1, 100, 100, 5});
        phases.push_back('{0, 0, 0, 0, 0, 5});
        phases.push_back('{511, 300, 2, 30000, 20000, 30});
        for (p = 0; p < 8; p++)
            phases.push_back('{$urandom_range(2, 48), 0, $urandom_range(0, 18),
                               $urandom_range(30000, 65535), $urandom_range(0, 30000), 90});

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (phases[pi]) begin
            ph = phases[pi];
            if (pi >= 5) begin send_pct = 70; recv_pct = 16; end
            if (pi >= 10) begin send_pct = 0; recv_pct = 0; end
            if (pi > 0) begin
                wait_idle();
                // never grow the window over store entries that were never written
                if (ph.win > written_hi && !(wr_pos == fill && fill == written_hi))
                    ph.win = written_hi;
                if (pi >= 6) ph.mins = $urandom_range(0, ph.win + 2);
                cfg_write(REG_WINDOW_LEN, ph.win);
                cfg_write(REG_EVAL_FILL, ph.mins);
                cfg_write(REG_BUCKET_COUNT, ph.bkt);
                cfg_write(REG_HIGH_THRESHOLD, ph.hi);
                cfg_write(REG_LOW_THRESHOLD, ph.lo);
            end
            base = $urandom_range(0, 65535) - 32768;
            if (base > 32000) base = 32000;
            for (i = 0; i < ph.items; i++) begin
                if (pi == 0 || pi == 2) sample_q.push_back(directed[i % directed.size()]);
                else sample_q.push_back(rand_sample(base));
            end
        end
        wait_idle();
        repeat (1500) @(posedge i_clk);
        $display("Checked %0d samples over %0d settings: %0d evaluated, %0d high, %0d low events.",
                 results, phases.size(), evals, hi_events, lo_events);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: window_histogram_entropy_monitor_core.f
sv/whem_pkg.sv
sv/whem_ram.sv
sv/whem_log2.sv
sv/whem_dp.sv
sv/whem_ctrl.sv
sv/window_histogram_entropy_monitor_core.sv
sim/tb_top.sv
